[hdl/emp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and hex helpers for the escaped message stream parser.
package emp_pkg;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_ARG    = 3'd1,
    KIND_ACCEPT = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_RESET  = 3'd4
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] FIELD_MAX = 8'hFF;

  function automatic logic hex_ok(input logic [7:0] ch);
    hex_ok = (ch inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  // Nibble value of a character already known to be a hex digit.
  function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
    logic [7:0] v;
    begin
      if (ch inside {[8'h30:8'h39]}) begin
        v = ch - 8'h30;
      end else if (ch inside {[8'h61:8'h66]}) begin
        v = ch - 8'h57;
      end else begin
        v = ch - 8'h37;
      end
      hex_nibble = v[3:0];
    end
  endfunction

endpackage

[hdl/emp_stream_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw bytes and parser results.
interface emp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface emp_result_if import emp_pkg::*;;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] data_byte;
  logic [7:0] field_index;

  modport source (output valid, output kind, output data_byte, output field_index,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input field_index,
                output ready);
endinterface

[hdl/escaped_message_stream_parser.sv]
`timescale 1ns / 1ps
// Escaped message stream parser: raw bytes in, decoded data and framing events out.
//
// Channels: raw carries one received byte per beat; result carries zero or one
// event per byte (kind, data_byte, field_index). Both use valid/ready, a beat
// moves when both are high.
// Path: a taken byte waits in the input register; its event is then loaded into
// the result register, which drives result.valid. Bytes that make no event
// (backslash, the x and hex digits of an escape, rejected hex pairs) only
// advance the parser state. Throughput: one byte per cycle while no byte with
// an event waits on a held result, set by the combinational decode between
// the input register and the result register.
// Reset: rst clears the parse mode, the field index, the title flag and both
// valid bits; the block takes a byte in the first cycle after reset.
// Stall: while result is held, the waiting byte stays in the input register
// and raw.ready drops only if that byte would produce an event; bytes that
// produce none still drain.
module escaped_message_stream_parser
  import emp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  emp_byte_if.sink        raw,
  emp_result_if.source    result
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX1   = 2'd2,
    MODE_HEX2   = 2'd3
  } mode_t;

  // Parser state
  mode_t      mode, mode_next;
  logic [7:0] first_hex, first_hex_next;
  logic [7:0] field, field_next;
  logic       title_seen, title_seen_next;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Result register
  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_data;
  logic [7:0] out_field;

  // Decode
  logic       has_res;
  kind_t      res_kind;
  logic [7:0] res_data;
  logic [7:0] res_field;
  logic       do_append;
  logic [7:0] app_val;

  logic out_free, s1_fire, raw_fire;

  assign out_free = !out_valid || result.ready;
  assign s1_fire  = s1_valid && (!has_res || out_free);
  assign raw.ready = !s1_valid || s1_fire;
  assign raw_fire = raw.valid && raw.ready;

  always_comb begin
    mode_next       = mode;
    first_hex_next  = first_hex;
    field_next      = field;
    title_seen_next = title_seen;
    has_res   = 1'b0;
    res_kind  = KIND_DATA;
    res_data  = 8'h00;
    res_field = field;
    do_append = 1'b0;
    app_val   = s1_byte;

    if (s1_byte == CH_NUL) begin
      mode_next       = MODE_NORMAL;
      first_hex_next  = 8'h00;
      field_next      = 8'h00;
      title_seen_next = 1'b0;
      has_res   = 1'b1;
      res_kind  = KIND_RESET;
      res_field = 8'h00;
    end else begin
      case (mode)
        MODE_ESCAPE: begin
          if (s1_byte == CH_X) begin
            mode_next = MODE_HEX1;
          end else begin
            mode_next = MODE_NORMAL;
            do_append = 1'b1;
            if (s1_byte == CH_N) begin
              app_val = CH_LF;
            end else if (s1_byte == CH_ZERO) begin
              app_val = 8'h00;
            end
          end
        end
        MODE_HEX1: begin
          first_hex_next = s1_byte;
          mode_next      = MODE_HEX2;
        end
        MODE_HEX2: begin
          mode_next = MODE_NORMAL;
          if (hex_ok(first_hex) && hex_ok(s1_byte)) begin
            do_append = 1'b1;
            app_val   = {hex_nibble(first_hex), hex_nibble(s1_byte)};
          end
        end
        default: begin
          if (s1_byte == CH_BSL) begin
            mode_next = MODE_ESCAPE;
          end else if (s1_byte == CH_PIPE) begin
            if (field != FIELD_MAX) begin
              field_next = field + 8'd1;
            end
            has_res   = 1'b1;
            res_kind  = KIND_ARG;
            res_field = field_next;
          end else if (s1_byte == CH_LF) begin
            field_next      = 8'h00;
            title_seen_next = 1'b0;
            has_res   = 1'b1;
            res_kind  = title_seen ? KIND_ACCEPT : KIND_DROP;
            res_field = field;
          end else begin
            do_append = 1'b1;
          end
        end
      endcase

      if (do_append) begin
        if (field == 8'h00) begin
          title_seen_next = 1'b1;
        end
        has_res   = 1'b1;
        res_kind  = KIND_DATA;
        res_data  = app_val;
        res_field = field;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_NORMAL;
      first_hex  <= 8'h00;
      field      <= 8'h00;
      title_seen <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (raw_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        mode       <= mode_next;
        first_hex  <= first_hex_next;
        field      <= field_next;
        title_seen <= title_seen_next;
      end

      if (s1_fire && has_res) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end

    if (raw_fire) begin
      s1_byte <= raw.in_byte;
    end
    if (s1_fire && has_res) begin
      out_kind  <= res_kind;
      out_data  <= res_data;
      out_field <= res_field;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_kind;
  assign result.data_byte   = out_data;
  assign result.field_index = out_field;

  // A zero byte returns the whole parser to its reset state.
  a_zero_resets: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_byte == CH_NUL |=> mode == MODE_NORMAL && field == 8'h00 && !title_seen)
    else $error("zero byte did not reset parser state");

  // Only data events carry a byte.
  a_data_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_DATA |-> out_data == 8'h00)
    else $error("non-data event carries a data byte");

  // A new argument never reports the title field.
  a_arg_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ARG |-> out_field != 8'h00)
    else $error("argument event reports field zero");

  // An empty input register always takes a byte.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> raw.ready)
    else $error("input stalled with empty input register");

  // A held result is not overwritten by a new event.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !(s1_fire && has_res))
    else $error("held result overwritten");

endmodule

[tb/escaped_message_stream_parser_checker.sv]
`timescale 1ns / 1ps
// Checker for the escaped message stream parser: predicts events per byte and compares them.
module escaped_message_stream_parser_checker
  import emp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  logic [7:0] byte_data,
  input  logic       event_valid,
  input  logic       event_ready,
  input  kind_t      event_kind,
  input  logic [7:0] event_data,
  input  logic [7:0] event_field,
  output int         outstanding,
  output int         fails
);

  typedef enum logic [1:0] {
    DEC_NORMAL,
    DEC_ESCAPE,
    DEC_HEX_HI,
    DEC_HEX_LO
  } decode_mode_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] field;
  } parse_event_t;

  parse_event_t  pending_events[$];
  decode_mode_t  dec_mode;
  logic [7:0]    hex_first;
  logic [7:0]    field_now;
  logic          title_has_data;
  int            fail_total = 0;

  function automatic void clear_parser();
    dec_mode = DEC_NORMAL;
    hex_first = 8'h00;
    field_now = 8'h00;
    title_has_data = 1'b0;
  endfunction

  function automatic logic digit_value(input logic [7:0] ch, output logic [3:0] nib);
    nib = 4'h0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      nib = 4'(ch - 8'h30);
      return 1'b1;
    end
    if (ch >= 8'h61 && ch <= 8'h66) begin
      nib = 4'(ch - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (ch >= 8'h41 && ch <= 8'h46) begin
      nib = 4'(ch - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic parse_event_t data_event(input logic [7:0] value);
    if (field_now == 8'h00) title_has_data = 1'b1;
    return '{KIND_DATA, value, field_now};
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields an event.
  function automatic logic decode_byte(input logic [7:0] b, output parse_event_t ev);
    logic [3:0] hi;
    logic [3:0] lo;
    logic       hi_ok;
    logic       lo_ok;
    ev = '{KIND_DATA, 8'h00, 8'h00};
    if (b == CH_NUL) begin
      clear_parser();
      ev = '{KIND_RESET, 8'h00, 8'h00};
      return 1'b1;
    end
    case (dec_mode)
      DEC_ESCAPE: begin
        if (b == CH_X) begin
          dec_mode = DEC_HEX_HI;
          return 1'b0;
        end
        dec_mode = DEC_NORMAL;
        if (b == CH_N) ev = data_event(CH_LF);
        else if (b == CH_ZERO) ev = data_event(8'h00);
        else ev = data_event(b);
        return 1'b1;
      end
      DEC_HEX_HI: begin
        hex_first = b;
        dec_mode = DEC_HEX_LO;
        return 1'b0;
      end
      DEC_HEX_LO: begin
        dec_mode = DEC_NORMAL;
        hi_ok = digit_value(hex_first, hi);
        lo_ok = digit_value(b, lo);
        if (!(hi_ok && lo_ok)) return 1'b0;
        ev = data_event({hi, lo});
        return 1'b1;
      end
      default: ;
    endcase
    if (b == CH_BSL) begin
      dec_mode = DEC_ESCAPE;
      return 1'b0;
    end
    if (b == CH_PIPE) begin
      if (field_now != FIELD_MAX) field_now = field_now + 8'd1;
      ev = '{KIND_ARG, 8'h00, field_now};
      return 1'b1;
    end
    if (b == CH_LF) begin
      ev = '{title_has_data ? KIND_ACCEPT : KIND_DROP, 8'h00, field_now};
      field_now = 8'h00;
      title_has_data = 1'b0;
      return 1'b1;
    end
    ev = data_event(b);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    parse_event_t got;
    parse_event_t want;
    parse_event_t ev;
    if (rst) begin
      pending_events.delete();
      clear_parser();
    end else begin
      // Compare first: an event never leaves in the cycle its byte is taken.
      if (event_valid && event_ready) begin
        got = '{event_kind, event_data, event_field};
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got kind %0d data %02h field %0d",
                   $time, got.kind, got.data, got.field);
          fail_total++;
        end else begin
          want = pending_events.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, got.kind);
            fail_total++;
          end
          if (got.data !== want.data) begin
            $display("%0t: data_byte mismatch, expected %02h, got %02h",
                     $time, want.data, got.data);
            fail_total++;
          end
          if (got.field !== want.field) begin
            $display("%0t: field_index mismatch, expected %0d, got %0d",
                     $time, want.field, got.field);
            fail_total++;
          end
        end
      end
      if (byte_valid && byte_ready) begin
        if (decode_byte(byte_data, ev)) pending_events.push_back(ev);
      end
    end
    outstanding <= pending_events.size();
    fails <= fail_total;
  end

endmodule

[tb/escaped_message_stream_parser_tb.sv]
`timescale 1ns / 1ps
// Top of the parser testbench: clock, reset, byte stimulus, result stalls and verdict.
module escaped_message_stream_parser_tb
  import emp_pkg::*;
;

  localparam int BYTE_COUNT = 950;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 100;

  logic clk;
  logic rst;
  int   outstanding;
  int   fails;
  int   sent;
  int   burst_left;
  int   hold_reqs;
  int   holds_served;
  int   rx_cycle;
  int   idle_cycles;
  bit   sat_done;
  bit   hold_asked;
  bit   pause_done;
  logic [7:0] warmup_seq [0:25];

  emp_byte_if   raw_ch ();
  emp_result_if res_ch ();

  escaped_message_stream_parser uut (
    .clk    (clk),
    .rst    (rst),
    .raw    (raw_ch),
    .result (res_ch)
  );

  escaped_message_stream_parser_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (raw_ch.valid),
    .byte_ready  (raw_ch.ready),
    .byte_data   (raw_ch.in_byte),
    .event_valid (res_ch.valid),
    .event_ready (res_ch.ready),
    .event_kind  (res_ch.kind),
    .event_data  (res_ch.data_byte),
    .event_field (res_ch.field_index),
    .outstanding (outstanding),
    .fails       (fails)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one byte and hold it until taken; gaps fall between bursts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        raw_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    raw_ch.valid <= 1'b1;
    raw_ch.in_byte <= b;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    sent++;
    burst_left--;
  endtask

  task automatic wait_drained();
    raw_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  task automatic send_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_BSL || b == CH_PIPE || b == CH_LF);
    send_byte(b);
  endtask

  task automatic send_escape();
    int pick;
    pick = $urandom_range(0, 6);
    send_byte(CH_BSL);
    case (pick)
      0: send_byte(CH_N);
      1: send_byte(CH_ZERO);
      2: send_byte(CH_PIPE);
      3: send_byte(CH_BSL);
      4: begin
        send_byte(CH_X);
        send_byte(hex_char());
        send_byte(hex_char());
      end
      5: begin
        // pair that is most likely not hex
        send_byte(CH_X);
        send_byte(8'($urandom_range(1, 255)));
        send_byte(8'($urandom_range(1, 255)));
      end
      default: send_byte(8'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic send_field(input int len);
    repeat (len) begin
      if ($urandom_range(0, 3) == 0) send_escape();
      else send_plain();
    end
  endtask

  task automatic send_message();
    int nargs;
    send_field(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
    nargs = $urandom_range(0, 3);
    repeat (nargs) begin
      send_byte(CH_PIPE);
      send_field($urandom_range(0, 4));
    end
    send_byte(CH_LF);
  endtask

  // Cut a message short in one of the awkward ways.
  task automatic send_broken();
    send_field($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) begin
      send_byte(CH_PIPE);
      send_field($urandom_range(0, 2));
    end
    case ($urandom_range(0, 3))
      0: send_byte(CH_NUL);
      1: begin
        send_byte(CH_BSL);
        send_byte(CH_LF);
      end
      2: begin
        send_byte(CH_BSL);
        send_byte(CH_X);
        send_byte(8'($urandom_range(1, 255)));
        send_byte(CH_LF);
      end
      default: begin
        send_byte(CH_BSL);
        send_byte(CH_NUL);
      end
    endcase
  endtask

  // Result side: rotating stall styles, plus long holds on request.
  initial begin
    res_ch.ready <= 1'b0;
    holds_served = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        holds_served++;
      end else begin
        case ((rx_cycle / 64) % 4)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= ((rx_cycle % 3) != 0);
        endcase
        rx_cycle++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (raw_ch.valid && raw_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d events outstanding", $time, outstanding);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    raw_ch.valid <= 1'b0;
    raw_ch.in_byte <= 8'h00;
    hold_reqs <= 0;
    sent = 0;
    burst_left = 0;
    sat_done = 1'b0;
    hold_asked = 1'b0;
    pause_done = 1'b0;
    // title byte, new argument, each escape, good and bad hex pairs, accept and
    // drop, top byte value, zero byte inside a hex escape, escaped pipe in argument
    warmup_seq = '{8'h41, CH_PIPE, CH_BSL, CH_N, CH_BSL, CH_ZERO,
                   CH_BSL, CH_X, 8'h66, 8'h46, CH_BSL, CH_X, 8'h67, 8'h31,
                   CH_LF, CH_LF, CH_BSL, CH_BSL, 8'hFF,
                   CH_BSL, CH_X, CH_NUL, CH_PIPE, CH_BSL, CH_PIPE, CH_LF};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (warmup_seq[i]) send_byte(warmup_seq[i]);
    wait_drained();

    while (sent < BYTE_COUNT) begin
      if (!sat_done && sent >= 300) begin
        // push the field index past its ceiling
        send_byte(8'h53);
        repeat (258) send_byte(CH_PIPE);
        send_byte(CH_LF);
        sat_done = 1'b1;
      end else if (!hold_asked && sent >= 500) begin
        hold_reqs <= hold_reqs + 1;
        hold_asked = 1'b1;
      end else if (!pause_done && sent >= 750) begin
        wait_drained();
        pause_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: send_broken();
          3, 4: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
          default: send_message();
        endcase
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
